@@ design/http_response_framer_assert.svh @@
// ----------------------------------------------------------------------------
// http_response_framer_assert.svh
// Assertion macros shared by the framer RTL (clock clk, reset rst_n).
// ----------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_FRAMER_ASSERT_SVH
`define HTTP_RESPONSE_FRAMER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define HRF_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("framer check failed");

// Next-cycle implication, disabled in reset
`define HRF_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("framer check failed");

`endif

@@ design/hrf_pkg.sv @@
// ----------------------------------------------------------------------------
// hrf_pkg
// Types, codes and character constants of the HTTP reply framer.
// ----------------------------------------------------------------------------
package hrf_pkg;

    localparam int unsigned LengthWidthDefault = 32;
    localparam int unsigned DigitLimitDefault  = 20;
    localparam logic [31:0] MaxReplyReset      = 32'd16777216;

    localparam logic [1:0] CMD_DATA    = 2'd0;
    localparam logic [1:0] CMD_CLOSE   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [1:0] OC_MORE      = 2'd0;
    localparam logic [1:0] OC_COMPLETE  = 2'd1;
    localparam logic [1:0] OC_MALFORMED = 2'd2;

    localparam logic [3:0] FL_NONE         = 4'd0;
    localparam logic [3:0] FL_HEAD_BIG     = 4'd1;
    localparam logic [3:0] FL_CLOSED_EMPTY = 4'd2;
    localparam logic [3:0] FL_CLOSED_HEAD  = 4'd3;
    localparam logic [3:0] FL_NO_STATUS    = 4'd4;
    localparam logic [3:0] FL_BAD_CODE     = 4'd5;
    localparam logic [3:0] FL_LENGTH_TWICE = 4'd6;
    localparam logic [3:0] FL_BAD_LENGTH   = 4'd7;
    localparam logic [3:0] FL_CLOSED_BODY  = 4'd8;
    localparam logic [3:0] FL_BODY_BIG     = 4'd9;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_COLON = 8'd58;

    localparam logic [2:0] PREFIX_LEN = 3'd7;
    localparam logic [3:0] NAME_LEN   = 4'd14;
    localparam logic [9:0] CODE_MIN   = 10'd100;
    localparam logic [13:0] CODE_MAX  = 14'd999;

    typedef enum logic [3:0] {
        PH_STATUS  = 4'b0001,
        PH_HEADERS = 4'b0010,
        PH_BODY    = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        logic [1:0] outcome;
        logic [9:0] status_code;
        logic [3:0] failure;
    } result_t;

    // "HTTP/1."
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            3'd5:    ch = 8'h31;
            3'd6:    ch = 8'h2E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "content-length", lower case
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h63;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h6C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ design/http_response_framer.sv @@
// ----------------------------------------------------------------------------
// http_response_framer
// Frames one HTTP/1.x reply byte by byte and streams its body.
// ----------------------------------------------------------------------------
// The result of an accepted item is loaded into the result register.
// One item per cycle unless a waiting result is stalled; the result register is the only stage.
// An item is taken while a finished result waits, as long as that one drains.
// Reset (rst_n low, asynchronous) returns to the status line phase with all
// counters cleared and the size limit at 16777216; the result register empties.
module http_response_framer #(
    parameter int unsigned LENGTH_WIDTH = hrf_pkg::LengthWidthDefault,
    parameter int unsigned DIGIT_LIMIT  = hrf_pkg::DigitLimitDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  hrf_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output hrf_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_wdata
);
    import hrf_pkg::*;

    `include "http_response_framer_assert.svh"

    // Width of the length arithmetic: room for the limit times ten plus a digit.
    localparam int unsigned CW = ((LENGTH_WIDTH > 32) ? LENGTH_WIDTH : 32) + 4;
    localparam logic [CW-1:0] LEN_CAP = {{(CW - LENGTH_WIDTH){1'b0}}, {LENGTH_WIDTH{1'b1}}};
    localparam logic [4:0] DL = 5'(DIGIT_LIMIT);

    // Line parser state: status line matchers and header line matchers.
    typedef struct packed {
        logic [2:0]              pfx;
        logic [1:0]              sfp;
        logic [9:0]              code;
        logic [4:0]              cdc;
        logic [1:0]              serr;
        logic [3:0]              np;
        logic [2:0]              lf;
        logic [1:0]              vp;
        logic [LENGTH_WIDTH-1:0] lv;
        logic [4:0]              ldc;
    } parse_t;

    localparam parse_t PARSE_CLEAR = '0;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_len_line(input parse_t s);
        return s.lf[0] && !s.lf[1] && (s.np == NAME_LEN);
    endfunction

    function automatic parse_t status_char(input parse_t s, input logic [7:0] c);
        parse_t r;
        logic [13:0] v;
        r = s;
        v = '0;
        if (!r.serr[0] && (r.pfx < PREFIX_LEN))
        begin
            if (c == prefix_char(r.pfx))
                r.pfx = r.pfx + 3'd1;
            else
                r.serr[0] = 1'b1;
        end
        if (r.sfp == 2'd0)
        begin
            if (c == CH_SPACE)
                r.sfp = 2'd1;
        end
        else if (r.sfp == 2'd1)
        begin
            if (c == CH_SPACE)
                r.sfp = 2'd2;
            else if (!r.serr[1])
            begin
                if (r.cdc <= DL)
                    r.cdc = r.cdc + 5'd1;
                if ((r.cdc > DL) || !is_digit(c))
                    r.serr[1] = 1'b1;
                else
                begin
                    v = 14'(r.code) * 14'd10 + 14'(c - 8'h30);
                    if (v > CODE_MAX)
                        r.serr[1] = 1'b1;
                    else
                        r.code = v[9:0];
                end
            end
        end
        return r;
    endfunction

    function automatic parse_t length_char(input parse_t s, input logic [7:0] c,
                                           input logic [CW-1:0] lim);
        parse_t r;
        logic [CW-1:0] v;
        r = s;
        v = '0;
        if (!r.lf[2])
        begin
            if (r.ldc <= DL)
                r.ldc = r.ldc + 5'd1;
            if ((r.ldc > DL) || !is_digit(c))
                r.lf[2] = 1'b1;
            else
            begin
                v = CW'(r.lv) * CW'(10) + CW'(c - 8'h30);
                if (v > lim)
                    r.lf[2] = 1'b1;
                else
                    r.lv = LENGTH_WIDTH'(v);
            end
        end
        return r;
    endfunction

    function automatic parse_t header_char(input parse_t s, input logic [7:0] c,
                                           input logic [CW-1:0] lim);
        parse_t r;
        logic [7:0] lc;
        r = s;
        lc = ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
        if (!r.lf[0])
        begin
            if (c == CH_COLON)
            begin
                r.lf[0] = 1'b1;
                if (is_len_line(r))
                begin
                    r.lv  = '0;
                    r.ldc = '0;
                    r.vp  = '0;
                end
            end
            else if (!r.lf[1])
            begin
                if ((r.np < NAME_LEN) && (lc == name_char(r.np)))
                    r.np = r.np + 4'd1;
                else
                    r.lf[1] = 1'b1;
            end
        end
        else if (is_len_line(r))
        begin
            if (r.vp == 2'd0)
            begin
                if (!is_blank(c))
                begin
                    r.vp = 2'd1;
                    r = length_char(r, c, lim);
                end
            end
            else if (r.vp == 2'd1)
            begin
                if (is_blank(c))
                    r.vp = 2'd2;
                else
                    r = length_char(r, c, lim);
            end
            else if (!is_blank(c))
                r.lf[2] = 1'b1;
        end
        return r;
    endfunction

    // Registers
    logic [31:0]             max_reg;
    phase_t                  phase_reg, phase_next;
    logic [31:0]             total_reg, total_next;
    logic [1:0]              term_reg, term_next;
    parse_t                  parse_reg, parse_next;
    logic                    lflag_reg, lflag_next;
    logic [1:0]              lcount_reg, lcount_next;
    logic [LENGTH_WIDTH-1:0] remain_reg, remain_next;
    logic                    result_valid_reg;
    result_t                 result_reg, result_next;

    logic accept;
    logic [CW-1:0] lim;

    assign item_stall   = result_valid_reg && result_stall;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign lim = (CW'(max_reg) < LEN_CAP) ? CW'(max_reg) : LEN_CAP;

    // Per-item step: update the matchers and form one result.
    always_comb
    begin
        logic [7:0]  c;
        logic        pending;
        logic        over;
        logic        fin;
        logic [1:0]  oc;
        logic [3:0]  fl;
        c           = item.data_byte;
        pending     = (term_reg == 2'd1) || (term_reg == 2'd3);
        fin         = 1'b0;
        oc          = OC_MORE;
        fl          = FL_NONE;
        phase_next  = phase_reg;
        total_next  = total_reg;
        term_next   = term_reg;
        parse_next  = parse_reg;
        lflag_next  = lflag_reg;
        lcount_next = lcount_reg;
        remain_next = remain_reg;
        result_next = '0;
        over        = 1'b0;

        case (item.command)
            CMD_RESTART:
            begin
                phase_next  = PH_STATUS;
                total_next  = '0;
                term_next   = '0;
                parse_next  = PARSE_CLEAR;
                lflag_next  = 1'b0;
                lcount_next = '0;
                remain_next = '0;
            end
            CMD_CLOSE:
            begin
                over = total_reg > max_reg;
                if ((phase_reg == PH_STATUS) || (phase_reg == PH_HEADERS))
                begin
                    fin = 1'b1;
                    oc  = OC_MALFORMED;
                    if (over)
                        fl = FL_HEAD_BIG;
                    else if (total_reg == '0)
                        fl = FL_CLOSED_EMPTY;
                    else
                        fl = FL_CLOSED_HEAD;
                end
                else if (phase_reg == PH_BODY)
                begin
                    fin = 1'b1;
                    if (lcount_reg == 2'd1)
                    begin
                        oc = OC_MALFORMED;
                        fl = FL_CLOSED_BODY;
                    end
                    else
                        oc = OC_COMPLETE;
                end
            end
            CMD_DATA:
            begin
                if (phase_reg != PH_DONE)
                begin
                    if (total_reg != 32'hFFFF_FFFF)
                        total_next = total_reg + 32'd1;
                    over = total_next > max_reg;
                    if (phase_reg == PH_BODY)
                    begin
                        if (lcount_reg == 2'd1)
                        begin
                            result_next.body_valid = 1'b1;
                            result_next.body_byte  = c;
                            if (remain_reg != '0)
                                remain_next = remain_reg - 1'b1;
                            if (remain_next == '0)
                            begin
                                fin = 1'b1;
                                oc  = OC_COMPLETE;
                            end
                        end
                        else if (over)
                        begin
                            fin = 1'b1;
                            oc  = OC_MALFORMED;
                            fl  = FL_BODY_BIG;
                        end
                        else
                        begin
                            result_next.body_valid = 1'b1;
                            result_next.body_byte  = c;
                        end
                    end
                    else if ((c == CH_LF) && (term_reg == 2'd3))
                    begin
                        // Blank line ends the head: report deferred errors now.
                        term_next = '0;
                        if (parse_reg.serr[0])
                        begin
                            fin = 1'b1; oc = OC_MALFORMED; fl = FL_NO_STATUS;
                        end
                        else if (parse_reg.serr[1] || (parse_reg.cdc == '0) ||
                                 (parse_reg.code < CODE_MIN))
                        begin
                            fin = 1'b1; oc = OC_MALFORMED; fl = FL_BAD_CODE;
                        end
                        else if (lcount_reg > 2'd1)
                        begin
                            fin = 1'b1; oc = OC_MALFORMED; fl = FL_LENGTH_TWICE;
                        end
                        else if ((lcount_reg == 2'd1) && lflag_reg)
                        begin
                            fin = 1'b1; oc = OC_MALFORMED; fl = FL_BAD_LENGTH;
                        end
                        else if (lcount_reg == 2'd1)
                        begin
                            if (parse_reg.lv == '0)
                            begin
                                fin = 1'b1; oc = OC_COMPLETE;
                            end
                            else
                            begin
                                remain_next = parse_reg.lv;
                                phase_next  = PH_BODY;
                            end
                        end
                        else if (over)
                        begin
                            fin = 1'b1; oc = OC_MALFORMED; fl = FL_BODY_BIG;
                        end
                        else
                            phase_next = PH_BODY;
                    end
                    else
                    begin
                        if ((c == CH_LF) && (term_reg == 2'd1))
                        begin
                            // Line end: close out the status line or a header line.
                            if (phase_reg == PH_STATUS)
                            begin
                                if ((parse_reg.sfp == 2'd0) || (parse_reg.pfx < PREFIX_LEN))
                                    parse_next.serr[0] = 1'b1;
                                phase_next = PH_HEADERS;
                            end
                            else if (is_len_line(parse_reg))
                            begin
                                if (lcount_reg < 2'd2)
                                    lcount_next = lcount_reg + 2'd1;
                                lflag_next = parse_reg.lf[2] || (parse_reg.ldc == '0);
                            end
                            parse_next.np = '0;
                            parse_next.lf = '0;
                            parse_next.vp = '0;
                            term_next     = 2'd2;
                        end
                        else
                        begin
                            // A held CR that was not part of the terminator is content.
                            if (pending)
                            begin
                                if (phase_reg == PH_STATUS)
                                    parse_next = status_char(parse_next, CH_CR);
                                else
                                    parse_next = header_char(parse_next, CH_CR, lim);
                            end
                            if (c == CH_CR)
                                term_next = (term_reg == 2'd2) ? 2'd3 : 2'd1;
                            else
                            begin
                                if (phase_reg == PH_STATUS)
                                    parse_next = status_char(parse_next, c);
                                else
                                    parse_next = header_char(parse_next, c, lim);
                                term_next = '0;
                            end
                        end
                        if (over)
                        begin
                            fin = 1'b1; oc = OC_MALFORMED; fl = FL_HEAD_BIG;
                        end
                    end
                end
            end
            default:
            begin
                result_next = '0;
            end
        endcase

        if (fin)
        begin
            phase_next              = PH_DONE;
            result_next.outcome     = oc;
            result_next.failure     = fl;
            result_next.status_code = (oc == OC_COMPLETE) ? parse_reg.code : '0;
        end
    end

    // Size limit register: user must write only between replies; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= MaxReplyReset;
        else if (cfg_we)
            max_reg <= cfg_wdata;
    end

    // Parser state: advance on every accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_STATUS;
            total_reg  <= '0;
            term_reg   <= '0;
            parse_reg  <= PARSE_CLEAR;
            lflag_reg  <= 1'b0;
            lcount_reg <= '0;
            remain_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            total_reg  <= total_next;
            term_reg   <= term_next;
            parse_reg  <= parse_next;
            lflag_reg  <= lflag_next;
            lcount_reg <= lcount_next;
            remain_reg <= remain_next;
        end
    end

    // Result register: load on accept, drop once transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (accept)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    // Checks
    `HRF_ASSERT_NEXT(a_end_goes_done, accept && (result_next.outcome != OC_MORE),
                     phase_reg == PH_DONE)
    `HRF_ASSERT_NOW(a_body_no_failure, result_valid && result.body_valid,
                    result.failure == FL_NONE)
    `HRF_ASSERT_NOW(a_code_only_complete, result_valid && (result.status_code != '0),
                    result.outcome == OC_COMPLETE)
    `HRF_ASSERT_NOW(a_remain_only_in_body, (phase_reg == PH_BODY) && (lcount_reg == 2'd1),
                    remain_reg != '0)

endmodule

@@ sim/tb_http_response_framer.sv @@
// ----------------------------------------------------------------------------
// tb_http_response_framer
// Self-checking bench for the HTTP reply framer: directed replies then random.
// ----------------------------------------------------------------------------
// Each accepted transfer is run through a cycle-free model of the framer kept
// in this module. The model yields exactly one result per transfer, and that
// result is queued. A monitor pops the queue on every result transfer and
// compares it field by field. The sender works in bursts, with or without
// random gaps. The receiver stalls in modes that change now and then: none, light
// and heavy. The size limit register is only written while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_http_response_framer;
    timeunit 1ns;
    timeprecision 1ps;

    import hrf_pkg::*;

    // Command code that the framer must ignore; the package does not name it.
    localparam logic [1:0] CMD_IGNORED  = 2'd3;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         RANDOM_ITEMS = 440;
    localparam int         DIGIT_MAX    = 20;
    localparam string      STATUS_TEXT  = "HTTP/1.";
    localparam string      LENGTH_NAME  = "content-length";

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    http_response_framer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Framer model: its own copy of the limit and of the per-reply state.
    // ------------------------------------------------------------------------
    logic [31:0] size_limit;
    phase_t      reply_phase;
    logic [31:0] bytes_seen;
    int          crlf_match;
    int          version_match;
    int          code_field;      // 0 before first space, 1 in code, 2 after
    int          code_acc;
    int          code_chars;
    logic [1:0]  status_bad;      // bit0 not a status line, bit1 bad code
    int          name_match;
    logic [2:0]  hdr_flags;       // bit0 colon, bit1 name mismatch, bit2 bad value
    int          value_field;     // 0 leading blanks, 1 digits, 2 trailing blanks
    logic [63:0] length_acc;
    int          length_chars;
    logic        length_unreadable;
    int          length_headers;
    logic [63:0] body_left;

    result_t expected_results[$];

    function automatic void clear_reply_state();
        reply_phase       = PH_STATUS;
        bytes_seen        = '0;
        crlf_match        = 0;
        version_match     = 0;
        code_field        = 0;
        code_acc          = 0;
        code_chars        = 0;
        status_bad        = '0;
        name_match        = 0;
        hdr_flags         = '0;
        value_field       = 0;
        length_acc        = '0;
        length_chars      = 0;
        length_unreadable = 1'b0;
        length_headers    = 0;
        body_left         = '0;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit on_length_line();
        return hdr_flags[0] && !hdr_flags[1] && name_match == LENGTH_NAME.len();
    endfunction

    function automatic void code_char(logic [7:0] c);
        int v;
        if (status_bad[1])
            return;
        if (code_chars <= DIGIT_MAX)
            code_chars++;
        if (code_chars > DIGIT_MAX || !is_digit(c))
        begin
            status_bad[1] = 1'b1;
            return;
        end
        v = code_acc * 10 + (c - "0");
        if (v > 999)
            status_bad[1] = 1'b1;
        else
            code_acc = v;
    endfunction

    function automatic void status_char(logic [7:0] c);
        if (!status_bad[0] && version_match < STATUS_TEXT.len())
        begin
            if (c == STATUS_TEXT[version_match])
                version_match++;
            else
                status_bad[0] = 1'b1;
        end
        if (code_field == 0)
        begin
            if (c == CH_SPACE)
                code_field = 1;
        end
        else if (code_field == 1)
        begin
            if (c == CH_SPACE)
                code_field = 2;
            else
                code_char(c);
        end
    endfunction

    function automatic void length_char(logic [7:0] c);
        logic [63:0] v;
        if (hdr_flags[2])
            return;
        if (length_chars <= DIGIT_MAX)
            length_chars++;
        if (length_chars > DIGIT_MAX || !is_digit(c))
        begin
            hdr_flags[2] = 1'b1;
            return;
        end
        v = length_acc * 10 + 64'(c - "0");
        if (v > {32'd0, size_limit})
            hdr_flags[2] = 1'b1;
        else
            length_acc = v;
    endfunction

    function automatic void header_char(logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (!hdr_flags[0])
        begin
            if (c == CH_COLON)
            begin
                hdr_flags[0] = 1'b1;
                if (on_length_line())
                begin
                    length_acc   = '0;
                    length_chars = 0;
                    value_field  = 0;
                end
                return;
            end
            if (!hdr_flags[1])
            begin
                if (name_match < LENGTH_NAME.len() && lc == LENGTH_NAME[name_match])
                    name_match++;
                else
                    hdr_flags[1] = 1'b1;
            end
            return;
        end
        if (!on_length_line())
            return;
        if (value_field == 0)
        begin
            if (!is_blank(c))
            begin
                value_field = 1;
                length_char(c);
            end
        end
        else if (value_field == 1)
        begin
            if (is_blank(c))
                value_field = 2;
            else
                length_char(c);
        end
        else if (!is_blank(c))
            hdr_flags[2] = 1'b1;
    endfunction

    function automatic void line_char(logic [7:0] c);
        if (reply_phase == PH_STATUS)
            status_char(c);
        else
            header_char(c);
    endfunction

    function automatic void close_line();
        if (reply_phase == PH_STATUS)
        begin
            if (code_field == 0 || version_match < STATUS_TEXT.len())
                status_bad[0] = 1'b1;
            reply_phase = PH_HEADERS;
        end
        else if (on_length_line())
        begin
            if (length_headers < 2)
                length_headers++;
            length_unreadable = hdr_flags[2] || length_chars == 0;
        end
        name_match  = 0;
        hdr_flags   = '0;
        value_field = 0;
    endfunction

    function automatic void end_reply(inout result_t r, input logic [1:0] oc,
                                      input logic [3:0] fl);
        r.outcome     = oc;
        r.failure     = fl;
        r.status_code = (oc == OC_COMPLETE) ? 10'(code_acc) : '0;
        reply_phase   = PH_DONE;
    endfunction

    function automatic void head_complete(inout result_t r);
        if (status_bad[0])
            end_reply(r, OC_MALFORMED, FL_NO_STATUS);
        else if (status_bad[1] || code_chars == 0 || code_acc < 100)
            end_reply(r, OC_MALFORMED, FL_BAD_CODE);
        else if (length_headers > 1)
            end_reply(r, OC_MALFORMED, FL_LENGTH_TWICE);
        else if (length_headers == 1 && length_unreadable)
            end_reply(r, OC_MALFORMED, FL_BAD_LENGTH);
        else if (length_headers == 1)
        begin
            if (length_acc == 0)
                end_reply(r, OC_COMPLETE, FL_NONE);
            else
            begin
                body_left   = length_acc;
                reply_phase = PH_BODY;
            end
        end
        else if (bytes_seen > size_limit)
            end_reply(r, OC_MALFORMED, FL_BODY_BIG);
        else
            reply_phase = PH_BODY;
    endfunction

    function automatic void head_byte(logic [7:0] c, inout result_t r);
        int p;
        bit held_cr;
        p = crlf_match;
        held_cr = (p == 1 || p == 3);
        if (c == CH_CR)
        begin
            if (held_cr)
                line_char(CH_CR);
            crlf_match = (p == 2) ? 3 : 1;
        end
        else if (c == CH_LF && p == 1)
        begin
            close_line();
            crlf_match = 2;
        end
        else if (c == CH_LF && p == 3)
        begin
            crlf_match = 0;
            head_complete(r);
            return;
        end
        else
        begin
            if (held_cr)
                line_char(CH_CR);
            line_char(c);
            crlf_match = 0;
        end
        if (bytes_seen > size_limit)
            end_reply(r, OC_MALFORMED, FL_HEAD_BIG);
    endfunction

    function automatic void body_char(logic [7:0] c, inout result_t r);
        if (length_headers == 1)
        begin
            r.body_valid = 1'b1;
            r.body_byte  = c;
            if (body_left > 0)
                body_left--;
            if (body_left == 0)
                end_reply(r, OC_COMPLETE, FL_NONE);
        end
        else if (bytes_seen > size_limit)
            end_reply(r, OC_MALFORMED, FL_BODY_BIG);
        else
        begin
            r.body_valid = 1'b1;
            r.body_byte  = c;
        end
    endfunction

    function automatic void connection_closed(inout result_t r);
        if (reply_phase == PH_STATUS || reply_phase == PH_HEADERS)
        begin
            if (bytes_seen > size_limit)
                end_reply(r, OC_MALFORMED, FL_HEAD_BIG);
            else
                end_reply(r, OC_MALFORMED,
                          (bytes_seen == 0) ? FL_CLOSED_EMPTY : FL_CLOSED_HEAD);
        end
        else if (reply_phase == PH_BODY)
        begin
            if (length_headers == 1)
                end_reply(r, OC_MALFORMED, FL_CLOSED_BODY);
            else
                end_reply(r, OC_COMPLETE, FL_NONE);
        end
    endfunction

    function automatic result_t predict_framer_result(item_t it);
        result_t r;
        r = '0;
        if (it.command == CMD_RESTART)
            clear_reply_state();
        else if (it.command == CMD_CLOSE)
            connection_closed(r);
        else if (it.command == CMD_DATA && reply_phase != PH_DONE)
        begin
            if (bytes_seen != 32'hFFFF_FFFF)
                bytes_seen++;
            if (reply_phase == PH_BODY)
                body_char(it.data_byte, r);
            else
                head_byte(it.data_byte, r);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: bursts of random length, separated by random gaps unless no_gaps is set.
    // ------------------------------------------------------------------------
    int items_sent;
    int burst_left;
    bit no_gaps;      // stretches where the sender never idles

    task automatic send_item(logic [1:0] cmd, logic [7:0] data);
        item_t it;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!no_gaps)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
        burst_left--;
        it.command   = cmd;
        it.data_byte = data;
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        expected_results.push_back(predict_framer_result(it));
        items_sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send_item(CMD_DATA, s[i]);
    endtask

    // Drop valid and let everything in flight drain before touching the limit.
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_size_limit(logic [31:0] value);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        size_limit = value;
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall pattern: a random mode that is redrawn when its run ends.
    // ------------------------------------------------------------------------
    int stall_mode;
    int stall_mode_left;

    always @(negedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(10, 60);
        end
        stall_mode_left--;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 3) == 0);
            default: result_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // ------------------------------------------------------------------------
    // Result monitor and watchdog, both sampling at the rising edge.
    // ------------------------------------------------------------------------
    int error_count;
    int mismatch_count;
    int results_seen;
    int completes_seen;
    int malformed_seen;
    int body_bytes_seen;
    int quiet_cycles;

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (result.outcome == OC_COMPLETE)
                completes_seen++;
            if (result.outcome == OC_MALFORMED)
                malformed_seen++;
            if (result.body_valid)
                body_bytes_seen++;
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("ERROR: result transfer with nothing expected: %p", result);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.body_valid !== want.body_valid
                    || result.body_byte !== want.body_byte
                    || result.outcome !== want.outcome
                    || result.status_code !== want.status_code
                    || result.failure !== want.failure)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: mismatch at %0t: expected %p, got %p",
                                 $realtime, want, result);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_sized_reply();
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 200 OK\r\nContent-Length: 5\r\n\r\nhello");
        send_item(CMD_RESTART, 8'hFF);
        send_text("HTTP/1.0 999 X\r\ncOnTeNt-LeNgTh:\t 0 \t\r\n\r\n");
        send_item(CMD_DATA, 8'hFF);          // after the end: ignored
        send_item(CMD_CLOSE, 8'h00);         // ignored too
    endtask

    task automatic test_status_line();
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTX/1.1 200 OK\r\n\r\n");
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 099\r\n\r\n");
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 1000\r\n\r\n");
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1  \r\n\r\n");     // empty code
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 00000000000000000000100\r\n\r\n");   // too many digits
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1\r\n\r\n");       // no space at all
    endtask

    task automatic test_length_header();
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 204 A\r\nContent-Length: 1\r\ncontent-length: 1\r\n\r\n");
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 204 A\r\nContent-Length: 1 2\r\n\r\n");
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 204 A\r\nContent-Length:\r\n\r\n");
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 204 A\r\nContent-Lengthx: 3\r\nX:\r\r\n\r\nabc");
        send_item(CMD_CLOSE, 8'h00);         // unbounded body ends at close
    endtask

    task automatic test_close_events();
        send_item(CMD_RESTART, 8'h00);
        send_item(CMD_CLOSE, 8'h00);         // closed before any byte
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 2");
        send_item(CMD_IGNORED, 8'hA5);
        send_item(CMD_CLOSE, 8'h00);         // closed in the head
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 301 M\r\nContent-Length: 10\r\n\r\nab");
        send_item(CMD_CLOSE, 8'h00);         // closed in a sized body
    endtask

    task automatic test_size_limits();
        set_size_limit(32'd0);
        send_item(CMD_RESTART, 8'h00);
        send_item(CMD_CLOSE, 8'h00);
        send_item(CMD_RESTART, 8'h00);
        send_text("H");
        set_size_limit(32'd1);
        send_item(CMD_RESTART, 8'h00);
        send_text("HT");
        set_size_limit(32'd24);
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 200 A\r\n\r\n0123456789");   // body runs over the limit
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 200 A\r\nContent-Length: 25\r\n\r\n");
        set_size_limit(32'hFFFF_FFFF);
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 200 A\r\nContent-Length: 4294967296\r\n\r\n");
        send_item(CMD_RESTART, 8'h00);
        send_text("HTTP/1.1 200 A\r\nContent-Length: 4294967295\r\n\r\nz");
    endtask

    // Build a mostly well-formed reply with random content.
    function automatic string random_reply(output int body_len);
        string s;
        string name;
        int headers;
        int len;
        s = ($urandom_range(0, 15) == 0) ? "HTTP/2.0 " : "HTTP/1.1 ";
        case ($urandom_range(0, 9))
            0:       s = {s, $sformatf("%0d", $urandom_range(0, 1500))};
            1:       s = {s, "2x0"};
            default: s = {s, $sformatf("%0d", $urandom_range(100, 599))};
        endcase
        s = {s, " OK\r\n"};
        body_len = $urandom_range(0, 12);
        headers  = $urandom_range(0, 3);
        len      = -1;
        for (int h = 0; h < headers; h++)
        begin
            case ($urandom_range(0, 3))
                0:       name = "content-LENGTH";
                1:       name = "Content-Lengt";
                2:       name = "Host";
                default: name = "Content-Length";
            endcase
            if (name.tolower() == LENGTH_NAME && $urandom_range(0, 4) != 0)
                s = {s, name, ": ", $sformatf("%0d", body_len), "\r\n"};
            else
                s = {s, name, ":\t", $sformatf("%0d", $urandom_range(0, 99)), " \r\n"};
        end
        return {s, "\r\n"};
    endfunction

    task automatic test_random_traffic();
        string head;
        int body_len;
        logic [7:0] c;
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if ((items_sent - start) % 250 == 0)
            begin
                case (((items_sent - start) / 250) % 4)
                    0:       set_size_limit(MaxReplyReset);
                    1:       set_size_limit($urandom_range(20, 60));
                    2:       set_size_limit(32'hFFFF_FFFF);
                    default: set_size_limit($urandom_range(0, 3));
                endcase
            end
            send_item(CMD_RESTART, 8'($urandom));
            if ($urandom_range(0, 7) == 0)
            begin
                // Noise: any command, any byte.
                repeat ($urandom_range(1, 16))
                    send_item(2'($urandom), 8'($urandom));
                continue;
            end
            head = random_reply(body_len);
            foreach (head[i])
            begin
                c = head[i];
                if ($urandom_range(0, 60) == 0)
                    c = 8'($urandom);        // corrupt one byte now and then
                send_item(CMD_DATA, c);
            end
            repeat (body_len + $urandom_range(0, 2))
                send_item(CMD_DATA, 8'($urandom));
            if ($urandom_range(0, 1) == 0)
                send_item(CMD_CLOSE, 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        size_limit   = MaxReplyReset;
        clear_reply_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        no_gaps = 1'b0;
        test_sized_reply();
        test_status_line();
        no_gaps = 1'b1;
        test_length_header();
        test_close_events();
        no_gaps = 1'b0;
        test_size_limits();
        test_random_traffic();

        drain();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            error_count++;
            $display("ERROR: %0d results never arrived", expected_results.size());
        end
        $display("Sent %0d transfers; checked %0d results (%0d body bytes).",
                 items_sent, results_seen, body_bytes_seen);
        $display("Replies ended: %0d complete, %0d malformed; %0d mismatches.",
                 completes_seen, malformed_seen, mismatch_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
